// File: hdl/price_amount_converter_macros.svh
// assertion macros for the price amount converter
`ifndef PRICE_AMOUNT_CONVERTER_MACROS_SVH
`define PRICE_AMOUNT_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define PAC_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define PAC_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PAC_ASSERT_IMPL(label, clk, rst_n, prop)
`define PAC_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: hdl/pac_pkg.sv
// shared types and constants for the price amount converter
package pac_pkg;
	localparam int unsigned FRACTION_BITS_DEF = 64;
	localparam int unsigned AMT_W = 128;
	localparam int unsigned WIDE_W = 256;
	localparam int unsigned NUM_CELLS = 64;
	localparam int unsigned MUL_BITS = AMT_W / NUM_CELLS;
	localparam int unsigned DIV_BITS = WIDE_W / NUM_CELLS;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_ZERO_DIV = 2'd2
	} status_t;

	localparam logic [0:0] IDX_PRICE_LOW  = 1'b0;
	localparam logic [0:0] IDX_PRICE_HIGH = 1'b1;

	// data travelling down the cell chain
	typedef struct packed {
		logic               valid;
		logic               act;
		logic               zero_price;
		logic [AMT_W-1:0]   amt;
		logic [AMT_W-1:0]   price;
		logic [WIDE_W-1:0]  acc;
		logic [AMT_W:0]     rem;
		logic [WIDE_W-1:0]  num;
	} chain_t;
endpackage

// File: hdl/pac_cell.sv
// one chain cell: a slice of shift-add multiply or restoring divide bits
module pac_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  pac_pkg::chain_t din,
	output pac_pkg::chain_t dout
);
	import pac_pkg::*;

	chain_t nxt;
	chain_t stage_q;
	logic [WIDE_W-1:0] acc_v;
	logic [AMT_W-1:0]  amt_v;
	logic [AMT_W:0]    rem_v;
	logic [WIDE_W-1:0] num_v;
	logic [AMT_W+1:0]  diff;

	// multiply: take top amount bit each step; divide: one quotient bit per step
	always_comb begin
		nxt = din;
		acc_v = din.acc;
		amt_v = din.amt;
		rem_v = din.rem;
		num_v = din.num;
		diff = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			if (!din.act) begin
				if (i < MUL_BITS) begin
					acc_v = {acc_v[WIDE_W-2:0], 1'b0};
					if (amt_v[AMT_W-1])
						acc_v = acc_v + {{(WIDE_W-AMT_W){1'b0}}, din.price};
					amt_v = {amt_v[AMT_W-2:0], 1'b0};
				end
			end else begin
				rem_v = {rem_v[AMT_W-1:0], num_v[WIDE_W-1]};
				num_v = {num_v[WIDE_W-2:0], 1'b0};
				diff = {1'b0, rem_v} - {2'b0, din.price};
				acc_v = {acc_v[WIDE_W-2:0], ~diff[AMT_W+1]};
				if (!diff[AMT_W+1])
					rem_v = diff[AMT_W:0];
			end
		end
		nxt.acc = acc_v;
		nxt.amt = amt_v;
		nxt.rem = rem_v;
		nxt.num = num_v;
	end

	// cell register, held while the chain stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (en) begin
			stage_q <= nxt;
		end
	end

	assign dout = stage_q;
endmodule

// File: hdl/price_amount_converter.sv
// top level: price amount converter with a chain of arithmetic cells
// pipeline: NUM_CELLS + 1 register stages, the NUM_CELLS cell registers and then the output register
// throughput: one item per cycle; the chain stalls only while a result waits unaccepted
// each cell does 2 multiply steps or 4 divide steps of the 256-bit quotient
// reset: arst_n clears valid flags; inverse price resets to one (high 1, low 0)
module price_amount_converter #(
	parameter int unsigned FRACTION_BITS = pac_pkg::FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [135:0]  s_tdata,  // amount_low, amount_high
	input  logic          s_tuser,  // action
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [135:0]  m_tdata,  // result_low, result_high, status, zero pad
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [0:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import pac_pkg::*;
	`include "price_amount_converter_macros.svh"

	logic [63:0] price_lo_q, price_hi_q;
	logic [AMT_W-1:0] price;
	chain_t head;
	chain_t link [NUM_CELLS+1];
	logic en;
	logic [WIDE_W-1:0] prod, quo;
	logic [AMT_W-1:0] res_val;
	logic ovf;
	logic [AMT_W-1:0] out_res_q;
	status_t out_st_q;
	logic out_vld_q;

	assign price = {price_hi_q, price_lo_q};
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_lo_q <= '0;
			price_hi_q <= 64'd1;
		end else if (cfg_valid) begin
			if (cfg_index == IDX_PRICE_LOW)
				price_lo_q <= cfg_data;
			else
				price_hi_q <= cfg_data;
		end
	end

	// chain advances when output is free or being taken
	assign en = !out_vld_q || m_tready;
	assign s_tready = en;

	// load: numerator is (amount << F) + price - 1 for the ceiling
	always_comb begin
		head = '0;
		head.valid = s_tvalid;
		head.act = s_tuser;
		head.zero_price = (price == '0);
		head.amt = s_tdata[AMT_W-1:0];
		head.price = price;
		head.num = ({{(WIDE_W-AMT_W){1'b0}}, s_tdata[AMT_W-1:0]} << FRACTION_BITS)
			+ {{(WIDE_W-AMT_W){1'b0}}, price - {{(AMT_W-1){1'b0}}, 1'b1}};
	end
	assign link[0] = head;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		pac_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .din(link[c]), .dout(link[c+1])
		);
	end

	// final shift and range check
	assign prod = link[NUM_CELLS].acc >> FRACTION_BITS;
	assign quo = link[NUM_CELLS].acc;
	assign res_val = link[NUM_CELLS].act ? quo[AMT_W-1:0] : prod[AMT_W-1:0];
	assign ovf = link[NUM_CELLS].act ? (quo[WIDE_W-1:AMT_W] != '0)
		: (prod[WIDE_W-1:AMT_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= link[NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (link[NUM_CELLS].zero_price) begin
				out_res_q <= '0;
				out_st_q <= ST_ZERO_DIV;
			end else if (ovf) begin
				out_res_q <= '0;
				out_st_q <= ST_OVERFLOW;
			end else begin
				out_res_q <= res_val;
				out_st_q <= ST_OK;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {6'b0, out_st_q, out_res_q};

	`PAC_ASSERT_IMPL(a_hold, clk, arst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata))
	`PAC_ASSERT_IMPL(a_zero, clk, arst_n, (m_tvalid && m_tdata[129:128] != 2'd0) |-> (m_tdata[127:0] == '0))
	`PAC_ASSERT_IMPL(a_rdy, clk, arst_n, (!m_tvalid) |-> s_tready)
	`PAC_ASSERT_RST(a_rst, clk, (!arst_n) |-> !m_tvalid)
endmodule

// File: tb/testbench.sv
// testbench for the price amount converter: random streams checked against a 256-bit predictor
`timescale 1ns / 1ps

module testbench;
	import pac_pkg::*;

	typedef struct {
		logic         act;
		logic [127:0] amt;
	} request_t;

	typedef struct {
		logic [127:0] amount;
		status_t      status;
	} conversion_t;

	localparam int unsigned SHIFT = 64;
	localparam int unsigned LATENCY = NUM_CELLS + 4;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [63:0]  cfg_data;

	request_t    pending_q[$];
	conversion_t conversion_q[$];
	logic [63:0] price_low;
	logic [63:0] price_high;
	int          mismatches;
	int          accepted_items;
	int          idle_cycles;
	int          burst_left;
	int          gap_left;
	int          hold_left;
	bit          long_hold_done;

	price_amount_converter i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock; reset is driven by the stimulus block
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact conversion at 256 bits with the current inverse price
	function automatic conversion_t convert(logic act, logic [127:0] amt);
		conversion_t  r;
		logic [255:0] price;
		logic [255:0] wide;
		price = {128'b0, price_high, price_low};
		r.amount = '0;
		r.status = ST_OK;
		if (price == '0) begin
			r.status = ST_ZERO_DIV;
			return r;
		end
		if (!act)
			wide = ({128'b0, amt} * price) >> SHIFT;
		else
			wide = (({128'b0, amt} << SHIFT) + price - 256'd1) / price;
		if (wide[255:128] != '0)
			r.status = ST_OVERFLOW;
		else
			r.amount = wide[127:0];
		return r;
	endfunction

	function automatic logic [127:0] rand_amount();
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 4))
			0: v = v >> $urandom_range(0, 127);
			1: v = v >> $urandom_range(60, 127);
			2: v = 128'($urandom_range(0, 1000));
			3: if ($urandom_range(0, 3) == 0) v = '1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [127:0] rand_price();
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			0: v = v >> $urandom_range(0, 127);
			1: v = 128'd1 << $urandom_range(0, 127);
			2: v = v >> $urandom_range(32, 96);
			default: ;
		endcase
		return v;
	endfunction

	// input driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				conversion_q.push_back(convert(s_tuser, s_tdata[127:0]));
				void'(pending_q.pop_front());
				accepted_items <= accepted_items + 1;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {8'b0, pending_q[0].amt};
					s_tuser <= pending_q[0].act;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random stall pattern plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!long_hold_done && accepted_items > 400) begin
			long_hold_done <= 1'b1;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0: hold_left <= $urandom_range(1, 8);
				1, 2: m_tready <= 1'b0;
				default: m_tready <= 1'b1;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (conversion_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result transfer %h", m_tdata);
			end else begin
				if (m_tdata[127:0] !== conversion_q[0].amount
						|| m_tdata[129:128] !== conversion_q[0].status) begin
					if (mismatches < 10)
						$display("mismatch: expected amount %h status %0d, got amount %h status %0d",
							conversion_q[0].amount, conversion_q[0].status,
							m_tdata[127:0], m_tdata[129:128]);
					mismatches <= mismatches + 1;
				end
				void'(conversion_q.pop_front());
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] index, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == IDX_PRICE_LOW)
			price_low = value;
		else
			price_high = value;
	endtask

	task automatic set_price(logic [127:0] p);
		write_reg(IDX_PRICE_LOW, p[63:0]);
		write_reg(IDX_PRICE_HIGH, p[127:64]);
	endtask

	task automatic queue_item(logic act, logic [127:0] amt);
		request_t r;
		r.act = act;
		r.amt = amt;
		pending_q.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_q.size() > 0 || conversion_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic queue_extremes();
		queue_item(1'b0, '0);
		queue_item(1'b1, '0);
		queue_item(1'b0, '1);
		queue_item(1'b1, '1);
		queue_item(1'b0, 128'd1);
		queue_item(1'b1, 128'd1);
		queue_item(1'b0, 128'd1 << 64);
		queue_item(1'b1, {64'b0, 64'hffff_ffff_ffff_ffff});
	endtask

	// stimulus in phases of inverse price settings
	initial begin
		logic [127:0] p;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		price_low = 64'd0;
		price_high = 64'd1;
		mismatches = 0;
		accepted_items = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// price one after reset
		queue_extremes();
		wait_drained();
		// zero price, all-ones price, smallest price
		set_price('0);
		queue_extremes();
		wait_drained();
		set_price('1);
		queue_extremes();
		wait_drained();
		set_price(128'd1);
		queue_extremes();
		wait_drained();

		// random prices, one phase with zero price, with random amounts
		for (int ph = 0; ph < 13; ph++) begin
			p = (ph == 6) ? 128'd0 : rand_price();
			set_price(p);
			for (int n = 0; n < 110; n++)
				queue_item(1'($urandom_range(0, 1)), rand_amount());
			wait_drained();
		end

		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && conversion_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/pac_pkg.sv
hdl/pac_cell.sv
hdl/price_amount_converter.sv
tb/testbench.sv
